### rtl/weighted_pixel_tap_accumulator_unit_defines.svh
// assertion macros for the weighted pixel tap accumulator checker
`ifndef WEIGHTED_PIXEL_TAP_ACCUMULATOR_UNIT_DEFINES_SVH
`define WEIGHTED_PIXEL_TAP_ACCUMULATOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define WPTA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define WPTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/wpta_pkg.sv
// shared widths, codes and types of the weighted pixel tap accumulator
`default_nettype none

package wpta_pkg;

    localparam int COLOUR_W = 8;
    localparam int WEIGHT_W = 16;
    localparam int MULT_W = 24;
    localparam int PROD_W = 32;
    localparam int CSUM_W = 40;
    localparam int ASUM_W = 32;
    localparam int NCH = 3;

    localparam int WEIGHT_FRACTION_BITS_DEF = 14;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_THREE_COLOURS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_ENABLE = 1'b1;

    typedef struct packed {
        logic three;
        logic alpha_en;
    } t_cfg;

    typedef struct packed {
        logic signed [MULT_W-1:0] mult;
        logic [NCH-1:0][COLOUR_W-1:0] colour;
        logic last;
        logic three;
        logic alpha_en;
    } t_tap;

endpackage

`default_nettype wire

### rtl/wpta_tap_if.sv
// tap request channel
`default_nettype none

interface wpta_tap_if;
    logic valid;
    logic ready;
    logic [wpta_pkg::COLOUR_W-1:0] colour_0;
    logic [wpta_pkg::COLOUR_W-1:0] colour_1;
    logic [wpta_pkg::COLOUR_W-1:0] colour_2;
    logic [wpta_pkg::COLOUR_W-1:0] alpha_in;
    logic signed [wpta_pkg::WEIGHT_W-1:0] tap_weight;
    logic last_tap;

    modport source (
        output valid, colour_0, colour_1, colour_2, alpha_in, tap_weight, last_tap,
        input ready
    );
    modport sink (
        input valid, colour_0, colour_1, colour_2, alpha_in, tap_weight, last_tap,
        output ready
    );
endinterface

`default_nettype wire

### rtl/wpta_pix_if.sv
// output pixel request channel
`default_nettype none

interface wpta_pix_if;
    logic valid;
    logic ready;
    logic [wpta_pkg::COLOUR_W-1:0] out_colour_0;
    logic [wpta_pkg::COLOUR_W-1:0] out_colour_1;
    logic [wpta_pkg::COLOUR_W-1:0] out_colour_2;
    logic [wpta_pkg::COLOUR_W-1:0] out_alpha;

    modport source (
        output valid, out_colour_0, out_colour_1, out_colour_2, out_alpha,
        input ready
    );
    modport sink (
        input valid, out_colour_0, out_colour_1, out_colour_2, out_alpha,
        output ready
    );
endinterface

`default_nettype wire

### rtl/wpta_front.sv
// front end: accepts taps and forms the per-tap weight, alpha-scaled if enabled
`default_nettype none

module wpta_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wpta_pkg::t_cfg  i_cfg,
    wpta_tap_if.sink        i_tap,
    input  logic            i_q_full,
    output logic            o_q_push,
    output wpta_pkg::t_tap  o_q_data
);

    localparam int CW = wpta_pkg::COLOUR_W;
    localparam int WW = wpta_pkg::WEIGHT_W;
    localparam int MW = wpta_pkg::MULT_W;

    logic            r_valid;
    wpta_pkg::t_tap  r_tap;
    wpta_pkg::t_tap  n_tap;
    logic            accept;
    logic signed [WW+CW:0] wa;

    assign i_tap.ready = !r_valid || !i_q_full;
    assign accept = i_tap.valid && i_tap.ready;
    assign o_q_push = r_valid && !i_q_full;
    assign o_q_data = r_tap;

    always_comb begin
        wa = $signed(i_tap.tap_weight) * $signed({1'b0, i_tap.alpha_in});
        n_tap.mult = i_cfg.alpha_en ? wa[MW-1:0] : MW'(i_tap.tap_weight);
        n_tap.colour = {i_tap.colour_2, i_tap.colour_1, i_tap.colour_0};
        n_tap.last = i_tap.last_tap;
        n_tap.three = i_cfg.three;
        n_tap.alpha_en = i_cfg.alpha_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tap <= n_tap;
        end
    end

endmodule

`default_nettype wire

### rtl/wpta_queue.sv
// short tap queue between front and back
`default_nettype none

module wpta_queue #(
    parameter int DEPTH = wpta_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  wpta_pkg::t_tap  i_push_data,
    output logic            o_full,
    output logic            o_pop_valid,
    output wpta_pkg::t_tap  o_pop_data,
    input  logic            i_pop_ready
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    wpta_pkg::t_tap    r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              pop;

    assign o_full = (r_cnt == CNT_FULL);
    assign o_pop_valid = (r_cnt != '0);
    assign o_pop_data = r_mem[r_rd];
    assign pop = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
            end
            unique case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/wpta_back.sv
// back end: accumulates taps, then rounds, unpremultiplies if alpha is enabled, and emits the pixel
`default_nettype none

module wpta_back #(
    parameter int WEIGHT_FRACTION_BITS = wpta_pkg::WEIGHT_FRACTION_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  wpta_pkg::t_tap  i_q_data,
    output logic            o_q_ready,
    wpta_pix_if.source      o_pix
);

    localparam int NCH = wpta_pkg::NCH;
    localparam int CW = wpta_pkg::COLOUR_W;
    localparam int MW = wpta_pkg::MULT_W;
    localparam int PW = wpta_pkg::PROD_W;
    localparam int CSW = wpta_pkg::CSUM_W;
    localparam int ASW = wpta_pkg::ASUM_W;
    localparam int EXW = CSW + 1;
    localparam int CNT_W = $clog2(CW);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CW - 1);
    localparam logic [EXW-1:0] HALF = EXW'(1) << (WEIGHT_FRACTION_BITS - 1);
    localparam logic [EXW-1:0] BYTE_MAX = EXW'(8'hFF);

    localparam logic [2:0] ST_ACC = 3'd0;
    localparam logic [2:0] ST_RND = 3'd1;
    localparam logic [2:0] ST_NUM = 3'd2;
    localparam logic [2:0] ST_DIV = 3'd3;
    localparam logic [2:0] ST_OUT = 3'd4;

    logic [2:0]              r_state;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [CSW-1:0]   r_cs [NCH];
    logic signed [ASW-1:0]   r_as;
    logic                    r_three;
    logic                    r_alpha;
    logic                    r_ovalid;

    logic signed [CSW-1:0]   r_fs [NCH];
    logic signed [ASW-1:0]   r_fa;
    logic [CW-1:0]           r_oa;
    logic [CW-1:0]           r_out_a;
    logic [CW-1:0]           r_q [NCH];
    logic [CW-1:0]           r_rem [NCH];
    logic [CW-1:0]           r_nlo [NCH];
    logic [NCH-1:0]          r_big;
    logic [NCH-1:0]          r_zero;
    logic [CW-1:0]           r_oc [NCH];

    logic signed [CSW-1:0]   n_cs [NCH];
    logic signed [ASW-1:0]   n_as;
    logic signed [PW:0]      prod [NCH];
    logic [CW-1:0]           rnd_a;
    logic [CW-1:0]           rnd_c [NCH];
    logic [EXW-1:0]          num_t [NCH];
    logic [EXW-1:0]          num_n [NCH];
    logic [NCH-1:0]          num_big;
    logic [CW:0]             div_sh [NCH];
    logic [NCH-1:0]          div_ge;
    logic [CW:0]             div_rem [NCH];
    logic                    out_free;
    logic                    pop;

    function automatic logic [CW-1:0] f_round(input logic signed [EXW-1:0] s);
        logic [EXW-1:0] t;
        logic [EXW-1:0] r;
        t = s + HALF;
        r = t >> WEIGHT_FRACTION_BITS;
        priority if (s <= 0) begin
            f_round = '0;
        end else if (r > BYTE_MAX) begin
            f_round = BYTE_MAX[CW-1:0];
        end else begin
            f_round = r[CW-1:0];
        end
    endfunction

    function automatic logic signed [CSW-1:0] f_sat_c(
        input logic signed [CSW-1:0] acc,
        input logic signed [PW-1:0] p
    );
        logic [CSW:0] s;
        s = {acc[CSW-1], acc} + {{(CSW + 1 - PW){p[PW-1]}}, p};
        priority if (s[CSW] != s[CSW-1]) begin
            f_sat_c = s[CSW] ? {1'b1, {(CSW - 1){1'b0}}} : {1'b0, {(CSW - 1){1'b1}}};
        end else begin
            f_sat_c = s[CSW-1:0];
        end
    endfunction

    function automatic logic signed [ASW-1:0] f_sat_a(
        input logic signed [ASW-1:0] acc,
        input logic signed [MW-1:0] p
    );
        logic [ASW:0] s;
        s = {acc[ASW-1], acc} + {{(ASW + 1 - MW){p[MW-1]}}, p};
        priority if (s[ASW] != s[ASW-1]) begin
            f_sat_a = s[ASW] ? {1'b1, {(ASW - 1){1'b0}}} : {1'b0, {(ASW - 1){1'b1}}};
        end else begin
            f_sat_a = s[ASW-1:0];
        end
    endfunction

    assign o_q_ready = (r_state == ST_ACC);
    assign pop = i_q_valid && o_q_ready;
    assign out_free = !r_ovalid || o_pix.ready;

    always_comb begin
        for (int k = 0; k < NCH; k++) begin
            prod[k] = $signed(i_q_data.mult) * $signed({1'b0, i_q_data.colour[k]});
            n_cs[k] = (k == 0 || i_q_data.three) ? f_sat_c(r_cs[k], prod[k][PW-1:0])
                                                 : r_cs[k];
        end
        n_as = i_q_data.alpha_en ? f_sat_a(r_as, i_q_data.mult) : r_as;
    end

    always_comb begin
        rnd_a = f_round(EXW'(r_fa));
        for (int k = 0; k < NCH; k++) begin
            rnd_c[k] = f_round(EXW'(r_fs[k]));
            num_t[k] = EXW'(r_fs[k]) + (EXW'(r_oa) << (WEIGHT_FRACTION_BITS - 1));
            num_n[k] = num_t[k] >> WEIGHT_FRACTION_BITS;
            num_big[k] = (num_n[k] >= (EXW'(r_oa) << CW));
            div_sh[k] = {r_rem[k], r_nlo[k][CW-1]};
            div_ge[k] = (div_sh[k] >= {1'b0, r_oa});
            div_rem[k] = div_ge[k] ? (div_sh[k] - {1'b0, r_oa}) : div_sh[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
            r_cnt <= '0;
            for (int k = 0; k < NCH; k++) begin
                r_cs[k] <= '0;
            end
            r_as <= '0;
            r_three <= 1'b1;
            r_alpha <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_ACC: begin
                    if (pop) begin
                        if (i_q_data.last) begin
                            for (int k = 0; k < NCH; k++) begin
                                r_cs[k] <= '0;
                            end
                            r_as <= '0;
                            r_three <= i_q_data.three;
                            r_alpha <= i_q_data.alpha_en;
                            r_state <= ST_RND;
                        end else begin
                            for (int k = 0; k < NCH; k++) begin
                                r_cs[k] <= n_cs[k];
                            end
                            r_as <= n_as;
                        end
                    end
                end
                ST_RND: begin
                    r_state <= r_alpha ? ST_NUM : ST_OUT;
                end
                ST_NUM: begin
                    r_cnt <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == LAST_STEP) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_state <= ST_ACC;
                    end
                end
                default: begin
                    r_state <= ST_ACC;
                end
            endcase
            if (r_state == ST_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_pix.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_ACC: begin
                if (pop && i_q_data.last) begin
                    for (int k = 0; k < NCH; k++) begin
                        r_fs[k] <= n_cs[k];
                    end
                    r_fa <= n_as;
                end
            end
            ST_RND: begin
                r_oa <= r_alpha ? rnd_a : '0;
                for (int k = 0; k < NCH; k++) begin
                    r_q[k] <= rnd_c[k];
                    r_big[k] <= 1'b0;
                    r_zero[k] <= (k != 0) && !r_three;
                end
            end
            ST_NUM: begin
                for (int k = 0; k < NCH; k++) begin
                    r_zero[k] <= (r_fs[k] <= 0) || (r_oa == '0) || ((k != 0) && !r_three);
                    r_big[k] <= num_big[k];
                    r_rem[k] <= num_n[k][2*CW-1:CW];
                    r_nlo[k] <= num_n[k][CW-1:0];
                    r_q[k] <= '0;
                end
            end
            ST_DIV: begin
                for (int k = 0; k < NCH; k++) begin
                    r_rem[k] <= div_rem[k][CW-1:0];
                    r_q[k] <= {r_q[k][CW-2:0], div_ge[k]};
                    r_nlo[k] <= {r_nlo[k][CW-2:0], 1'b0};
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    r_out_a <= r_oa;
                    for (int k = 0; k < NCH; k++) begin
                        priority if (r_zero[k]) begin
                            r_oc[k] <= '0;
                        end else if (r_big[k]) begin
                            r_oc[k] <= BYTE_MAX[CW-1:0];
                        end else begin
                            r_oc[k] <= r_q[k];
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_pix.valid = r_ovalid;
    assign o_pix.out_colour_0 = r_oc[0];
    assign o_pix.out_colour_1 = r_oc[1];
    assign o_pix.out_colour_2 = r_oc[2];
    assign o_pix.out_alpha = r_out_a;

endmodule

`default_nettype wire

### rtl/weighted_pixel_tap_accumulator_unit.sv
// top level of the weighted pixel tap accumulator
//
//   channel   dir  handshake      payload
//   i_tap     in   valid/ready    colour_0..2, alpha_in, tap_weight, last_tap
//   o_pix     out  valid/ready    out_colour_0..2, out_alpha
//   cfg       in   i_cfg_we       i_cfg_idx, i_cfg_data
//
// taps are taken one per cycle while the tap queue has room; the back end
// retires one tap per cycle from the queue while it is accumulating
// after its last tap a pixel is rounded and emitted without alpha; with alpha
// it also goes through numerator setup and an 8-step restoring divide per channel
// synchronous reset clears queue, accumulators and output valid; config
// returns to three colours, alpha off; no clearing pass
// a stalled output holds the back end while the front keeps filling the queue
`default_nettype none

module weighted_pixel_tap_accumulator_unit #(
    parameter int WEIGHT_FRACTION_BITS = wpta_pkg::WEIGHT_FRACTION_BITS_DEF,
    parameter int QUEUE_DEPTH = wpta_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wpta_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [wpta_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    wpta_tap_if.sink                            i_tap,
    wpta_pix_if.source                          o_pix
);

    wpta_pkg::t_cfg  r_cfg;
    logic            q_push;
    wpta_pkg::t_tap  q_push_data;
    logic            q_full;
    logic            q_pop_valid;
    wpta_pkg::t_tap  q_pop_data;
    logic            q_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.three <= 1'b1;
            r_cfg.alpha_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wpta_pkg::CFG_THREE_COLOURS: r_cfg.three <= i_cfg_data[0];
                wpta_pkg::CFG_ALPHA_ENABLE:  r_cfg.alpha_en <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    wpta_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_tap    (i_tap),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_push_data)
    );

    wpta_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .o_pop_valid (q_pop_valid),
        .o_pop_data  (q_pop_data),
        .i_pop_ready (q_pop_ready)
    );

    wpta_back #(
        .WEIGHT_FRACTION_BITS (WEIGHT_FRACTION_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_pop_valid),
        .i_q_data  (q_pop_data),
        .o_q_ready (q_pop_ready),
        .o_pix     (o_pix)
    );

endmodule

`default_nettype wire

### rtl/wpta_checker.sv
// port-level checker for the weighted pixel tap accumulator, with its bind
`default_nettype none
`include "weighted_pixel_tap_accumulator_unit_defines.svh"

module wpta_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_cfg_we,
    input logic [wpta_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input logic [wpta_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [wpta_pkg::COLOUR_W-1:0]    i_out_colour_0,
    input logic [wpta_pkg::COLOUR_W-1:0]    i_out_colour_1,
    input logic [wpta_pkg::COLOUR_W-1:0]    i_out_colour_2,
    input logic [wpta_pkg::COLOUR_W-1:0]    i_out_alpha
);

    logic r_three;
    logic r_alpha;

    // shadow of the mode registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_three <= 1'b1;
            r_alpha <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wpta_pkg::CFG_THREE_COLOURS: r_three <= i_cfg_data[0];
                wpta_pkg::CFG_ALPHA_ENABLE:  r_alpha <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    `WPTA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_colour_0) && $stable(i_out_colour_1) && $stable(i_out_colour_2) && $stable(i_out_alpha), "stalled pixel changed")
    `WPTA_ASSERT_NOW(a_grey_zero, i_clk, i_rst_n, i_out_valid && !r_three, i_out_colour_1 == '0 && i_out_colour_2 == '0, "grey pixel has nonzero extra channels")
    `WPTA_ASSERT_NOW(a_alpha_off, i_clk, i_rst_n, i_out_valid && !r_alpha, i_out_alpha == '0, "alpha nonzero with alpha disabled")
    `WPTA_ASSERT_NOW(a_clear_pixel, i_clk, i_rst_n, i_out_valid && r_alpha && i_out_alpha == '0, i_out_colour_0 == '0 && i_out_colour_1 == '0 && i_out_colour_2 == '0, "transparent pixel has colour")

endmodule

bind weighted_pixel_tap_accumulator_unit wpta_checker u_wpta_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_cfg_we       (i_cfg_we),
    .i_cfg_idx      (i_cfg_idx),
    .i_cfg_data     (i_cfg_data),
    .i_out_valid    (o_pix.valid),
    .i_out_ready    (o_pix.ready),
    .i_out_colour_0 (o_pix.out_colour_0),
    .i_out_colour_1 (o_pix.out_colour_1),
    .i_out_colour_2 (o_pix.out_colour_2),
    .i_out_alpha    (o_pix.out_alpha)
);

`default_nettype wire
